// ----- rtl/icl_pkg.sv -----
// Package for the interrupt controller change latch block.
// Holds the operation and register offset codes and the item structs.
// Depends on nothing.
`default_nettype none

package icl_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LEVEL = 2'd2;
  localparam logic [1:0] OP_PULSE = 2'd3;

  localparam logic [3:0] OFS_EVENTS = 4'h0;
  localparam logic [3:0] OFS_MASK   = 4'h4;
  localparam logic [3:0] OFS_CLEAR  = 4'h8;
  localparam logic [3:0] OFS_LEVELS = 4'hC;

  localparam logic [31:0] MODE_ACK_BIT = 32'h8000_0000;
  localparam int          MODE_BIT_POS = 31;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  reg_offset;
    logic [31:0] write_data;
    logic [4:0]  source_index;
    logic        source_level;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/icl_core.sv -----
// State registers and single-pass update logic of the interrupt controller.
// Applies one command per enabled cycle and computes its result item.
// Depends on icl_pkg.
`default_nettype none

module icl_core #(
  parameter int NUM_SOURCES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire icl_pkg::cmd_t cmd,
  output icl_pkg::rsp_t     rsp
);
  import icl_pkg::*;

  localparam logic [NUM_SOURCES-1:0] ACK_MASK = MODE_ACK_BIT[NUM_SOURCES-1:0];
  localparam logic [5:0] SRC_COUNT = 6'(NUM_SOURCES);

  logic [NUM_SOURCES-1:0] event_bits, event_bits_next;
  logic [NUM_SOURCES-1:0] enable_mask, enable_mask_next;
  logic [NUM_SOURCES-1:0] source_levels, source_levels_next;
  logic [NUM_SOURCES-1:0] change_latch, change_latch_next;
  logic                   latch_mode, latch_mode_next;

  logic [NUM_SOURCES-1:0] wdata;
  logic [NUM_SOURCES-1:0] src_bit;
  logic [NUM_SOURCES-1:0] rise;
  logic                   idx_ok;
  logic [31:0]            rdata;

  assign wdata  = cmd.write_data[NUM_SOURCES-1:0];
  assign idx_ok = ({1'b0, cmd.source_index} < SRC_COUNT);
  assign src_bit = idx_ok ? (NUM_SOURCES'(1) << cmd.source_index) : '0;
  assign rise   = src_bit & ~source_levels;

  always_comb begin
    event_bits_next    = event_bits;
    enable_mask_next   = enable_mask;
    source_levels_next = source_levels;
    change_latch_next  = change_latch;
    latch_mode_next    = latch_mode;
    rdata              = '0;
    unique case (cmd.opcode)
      OP_READ: begin
        unique case (cmd.reg_offset)
          OFS_EVENTS: rdata = 32'(event_bits);
          OFS_MASK:   rdata = 32'(enable_mask);
          OFS_LEVELS: rdata = 32'(source_levels);
          default:    rdata = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (cmd.reg_offset)
          OFS_EVENTS: begin
            event_bits_next = event_bits & ~(wdata & ~ACK_MASK);
          end
          OFS_CLEAR: begin
            event_bits_next = event_bits & ~(wdata & ~ACK_MASK);
            latch_mode_next = cmd.write_data[MODE_BIT_POS];
            if (cmd.write_data[MODE_BIT_POS]) begin
              change_latch_next = '0;
            end
          end
          OFS_MASK: begin
            enable_mask_next  = wdata;
            change_latch_next = change_latch |
                                ((event_bits | source_levels) & wdata & ~enable_mask);
          end
          default: begin
          end
        endcase
      end
      OP_LEVEL: begin
        if (cmd.source_level) begin
          source_levels_next = source_levels | src_bit;
          event_bits_next    = event_bits | rise;
          change_latch_next  = change_latch | (rise & enable_mask);
        end else begin
          source_levels_next = source_levels & ~src_bit;
          change_latch_next  = change_latch | (src_bit & source_levels & enable_mask);
        end
      end
      OP_PULSE: begin
        event_bits_next   = event_bits | src_bit;
        change_latch_next = change_latch | (src_bit & enable_mask);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.read_data = rdata;
    if (latch_mode_next) begin
      rsp.irq_line = |(change_latch_next & enable_mask_next);
    end else begin
      rsp.irq_line = |((event_bits_next | source_levels_next) & enable_mask_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_bits    <= '0;
      enable_mask   <= '0;
      source_levels <= '0;
      change_latch  <= '0;
      latch_mode    <= 1'b0;
    end else if (fire) begin
      event_bits    <= event_bits_next;
      enable_mask   <= enable_mask_next;
      source_levels <= source_levels_next;
      change_latch  <= change_latch_next;
      latch_mode    <= latch_mode_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/interrupt_controller_change_latch.sv -----
// Top level of the interrupt controller with per-source change latch.
// Input item register, the update core and the result register.
// Depends on icl_pkg and icl_core.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | opcode reg_offset write_data
//           |                      | source_index source_level
//   out     | out_valid / out_ready| read_data irq_line
//
// An accepted item is held in the input register until the result register can
// take its result, then applied to the state with its result written to the
// result register. One item is taken per cycle as long as results are drained.
// The input stalls only when both registers are full and the result is not taken.
// Reset clears all state and both valid flags; no clearing pass is needed.
`default_nettype none

module interrupt_controller_change_latch #(
  parameter int NUM_SOURCES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  reg_offset,
  input  wire logic [31:0] write_data,
  input  wire logic [4:0]  source_index,
  input  wire logic        source_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             irq_line
);
  import icl_pkg::*;

  cmd_t cmd_reg;
  logic cmd_full;
  rsp_t rsp_core;
  rsp_t rsp_reg;
  logic advance;

  assign advance  = cmd_full && (!out_valid || out_ready);
  assign in_ready = !cmd_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
    end else if (in_ready) begin
      cmd_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_reg.opcode       <= opcode;
      cmd_reg.reg_offset   <= reg_offset;
      cmd_reg.write_data   <= write_data;
      cmd_reg.source_index <= source_index;
      cmd_reg.source_level <= source_level;
    end
  end

  icl_core #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cmd  (cmd_reg),
    .rsp  (rsp_core)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_reg <= rsp_core;
    end
  end

  assign read_data = rsp_reg.read_data;
  assign irq_line  = rsp_reg.irq_line;

endmodule

`default_nettype wire

// ----- sim/irq_tracker_pkg.sv -----
// Scoreboard class for the interrupt controller change latch testbench.
// Keeps its own copy of the controller state and predicts each result item.
// Depends on icl_pkg for the operation codes, offsets and item structs.
`timescale 1ns / 1ps

package irq_tracker_pkg;

  import icl_pkg::*;

  localparam int TRACKED_SOURCES = 32;

  class irq_tracker;

    logic [31:0] event_word;
    logic [31:0] enable_word;
    logic [31:0] level_word;
    logic [31:0] latch_word;
    logic        clear_mode;
    rsp_t        pending_rsp[$];
    int unsigned fails;

    function new();
      event_word  = '0;
      enable_word = '0;
      level_word  = '0;
      latch_word  = '0;
      clear_mode  = 1'b0;
      fails       = 0;
    endfunction

    function void mark_edge(logic [31:0] bit_sel);
      event_word |= bit_sel;
      latch_word |= enable_word & bit_sel;
    endfunction

    function rsp_t apply_command(cmd_t c);
      logic [31:0] bit_sel;
      logic [31:0] fresh;
      rsp_t        r;
      r.read_data = '0;
      bit_sel = 32'd1 << c.source_index;
      case (c.opcode)
        OP_READ: begin
          case (c.reg_offset)
            OFS_EVENTS: r.read_data = event_word;
            OFS_MASK:   r.read_data = enable_word;
            OFS_LEVELS: r.read_data = level_word;
            default:    r.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          case (c.reg_offset)
            OFS_EVENTS, OFS_CLEAR: begin
              event_word &= ~(c.write_data & ~MODE_ACK_BIT);
              if (c.reg_offset == OFS_CLEAR) begin
                clear_mode = c.write_data[MODE_BIT_POS];
                if (clear_mode) latch_word = '0;
              end
            end
            OFS_MASK: begin
              fresh = c.write_data & ~enable_word;
              enable_word = c.write_data;
              latch_word |= (event_word | level_word) & fresh;
            end
            default: ;
          endcase
        end
        OP_LEVEL: begin
          if (c.source_index < TRACKED_SOURCES) begin
            if (c.source_level) begin
              if ((level_word & bit_sel) == '0) mark_edge(bit_sel);
              level_word |= bit_sel;
            end else begin
              if ((level_word & enable_word & bit_sel) != '0) latch_word |= bit_sel;
              level_word &= ~bit_sel;
            end
          end
        end
        default: begin
          if (c.source_index < TRACKED_SOURCES) mark_edge(bit_sel);
        end
      endcase
      if (clear_mode) r.irq_line = |(latch_word & enable_word);
      else r.irq_line = |((event_word | level_word) & enable_word);
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_rsp.push_back(apply_command(c));
    endfunction

    function int pending_count();
      return pending_rsp.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
      fails++;
    endtask

    task check_response(rsp_t r);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("unexpected item read_data", r.read_data, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (r.read_data !== want.read_data) report("read_data", r.read_data, want.read_data);
        if (r.irq_line !== want.irq_line)
          report("irq_line", 32'(r.irq_line), 32'(want.irq_line));
      end
    endtask

  endclass

endpackage

// ----- sim/testbench.sv -----
// Testbench for interrupt_controller_change_latch: directed and random items
// with random gaps on both channels, checked against irq_tracker predictions.
// Depends on icl_pkg, irq_tracker_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;

  import icl_pkg::*;
  import irq_tracker_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [3:0]  reg_offset;
  logic [31:0] write_data;
  logic [4:0]  source_index;
  logic        source_level;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic        irq_line;

  logic        src_quiet  = 1'b0;
  logic        sink_quiet = 1'b0;
  int unsigned cycle_count = 0;
  irq_tracker  tracker = new();

  interrupt_controller_change_latch uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .reg_offset   (reg_offset),
    .write_data   (write_data),
    .source_index (source_index),
    .source_level (source_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .irq_line     (irq_line)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      tracker.note_command(cmd_t'{opcode, reg_offset, write_data, source_index, source_level});
    if (!rst && out_valid && out_ready)
      tracker.check_response(rsp_t'{read_data, irq_line});
  end

  task issue(logic [1:0] op, logic [3:0] ofs, logic [31:0] data, logic [4:0] idx,
             logic lvl);
    int gap;
    if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    reg_offset   <= ofs;
    write_data   <= data;
    source_index <= idx;
    source_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return MODE_ACK_BIT | $urandom;
      default: return $urandom;
    endcase
  endfunction

  function logic [3:0] pick_offset();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       return OFS_EVENTS;
      1:       return OFS_MASK;
      2:       return OFS_CLEAR;
      default: return OFS_LEVELS;
    endcase
  endfunction

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = ~sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [1:0] op;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_READ;
    reg_offset   = OFS_EVENTS;
    write_data   = '0;
    source_index = '0;
    source_level = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue(OP_READ,  OFS_EVENTS, '0, 5'd0, 1'b0);
    issue(OP_READ,  OFS_MASK,   '0, 5'd0, 1'b0);
    issue(OP_READ,  OFS_CLEAR,  '0, 5'd0, 1'b0);
    issue(OP_READ,  4'hF,       '0, 5'd0, 1'b0);
    issue(OP_PULSE, OFS_EVENTS, '0, 5'd31, 1'b0);
    issue(OP_WRITE, OFS_MASK,   32'hFFFF_FFFF, 5'd0, 1'b0);
    issue(OP_PULSE, OFS_EVENTS, '0, 5'd0, 1'b1);
    issue(OP_LEVEL, OFS_EVENTS, '0, 5'd5, 1'b1);
    issue(OP_LEVEL, OFS_EVENTS, '0, 5'd5, 1'b1);
    issue(OP_LEVEL, OFS_EVENTS, '0, 5'd5, 1'b0);
    issue(OP_READ,  OFS_LEVELS, '0, 5'd0, 1'b0);
    issue(OP_WRITE, OFS_EVENTS, 32'hFFFF_FFFF, 5'd0, 1'b0);
    issue(OP_READ,  OFS_EVENTS, '0, 5'd0, 1'b0);
    issue(OP_WRITE, OFS_CLEAR,  MODE_ACK_BIT, 5'd0, 1'b0);
    issue(OP_PULSE, OFS_EVENTS, '0, 5'd31, 1'b0);
    issue(OP_PULSE, OFS_EVENTS, '0, 5'd31, 1'b0);
    issue(OP_WRITE, OFS_MASK,   32'h0000_0000, 5'd0, 1'b0);
    issue(OP_LEVEL, OFS_EVENTS, '0, 5'd17, 1'b1);
    issue(OP_WRITE, OFS_MASK,   32'h0002_0001, 5'd0, 1'b0);
    issue(OP_WRITE, OFS_LEVELS, 32'hFFFF_FFFF, 5'd0, 1'b0);
    issue(OP_WRITE, 4'h6,       32'hFFFF_FFFF, 5'd0, 1'b0);
    issue(OP_READ,  OFS_LEVELS, '0, 5'd0, 1'b0);
    issue(OP_WRITE, OFS_CLEAR,  32'h7FFF_FFFF, 5'd0, 1'b0);
    issue(OP_READ,  OFS_MASK,   '0, 5'd0, 1'b0);

    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_READ;
        3, 4:    op = OP_WRITE;
        5, 6, 7: op = OP_LEVEL;
        default: op = OP_PULSE;
      endcase
      issue(op, pick_offset(), pick_word(), 5'($urandom_range(0, 31)),
            1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/icl_pkg.sv
rtl/icl_core.sv
rtl/interrupt_controller_change_latch.sv
sim/irq_tracker_pkg.sv
sim/testbench.sv
